// ===== design/aabb_pkg.sv =====
// Shared types and constants for the box table overlap query block.
// No dependencies.
package aabb_pkg;

	localparam int CAPACITY   = 32;
	localparam int COORD_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int SLOT_BITS  = 5;
	localparam int MASK_BITS  = 32;
	localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int CMP_BITS   = (CNT_BITS > SLOT_BITS) ? CNT_BITS : SLOT_BITS;

	localparam logic [2:0] CMD_INSERT      = 3'd0;
	localparam logic [2:0] CMD_UPDATE      = 3'd1;
	localparam logic [2:0] CMD_ERASE_MATCH = 3'd2;
	localparam logic [2:0] CMD_ERASE_INDEX = 3'd3;
	localparam logic [2:0] CMD_CLEAR       = 3'd4;
	localparam logic [2:0] CMD_OVERLAP     = 3'd5;
	localparam logic [2:0] CMD_CONTAINED   = 3'd6;
	localparam logic [2:0] CMD_MEMBER      = 3'd7;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NO_MATCH = 2'd2;
	localparam logic [1:0] STAT_BAD_IDX  = 2'd3;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t lx;
		coord_t ly;
		coord_t lz;
		coord_t hx;
		coord_t hy;
		coord_t hz;
	} box_t;

	typedef struct packed {
		logic [2:0]            cmd;
		logic [FIELD_BITS-1:0] low_x;
		logic [FIELD_BITS-1:0] low_y;
		logic [FIELD_BITS-1:0] low_z;
		logic [FIELD_BITS-1:0] high_x;
		logic [FIELD_BITS-1:0] high_y;
		logic [FIELD_BITS-1:0] high_z;
		logic [SLOT_BITS-1:0]  slot;
	} req_t;

	typedef struct packed {
		logic [MASK_BITS-1:0] hit_mask;
		logic                 any_hit;
		logic [5:0]           hit_count;
		logic [5:0]           entries_used;
		logic [1:0]           status;
	} rsp_t;

	typedef struct packed {
		logic cap_en;
		logic wr_en;
		logic live;
	} cell_ctl_t;

endpackage

// ===== design/aabb_cell.sv =====
// One table entry: stored box, compare against the broadcast query box,
// and a link in the first-match chain. Depends on aabb_pkg.
module aabb_cell import aabb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic [2:0] mode,
	input  box_t      qry,
	input  box_t      wr_box,
	input  logic      seen_in,
	output box_t      box,
	output logic      hit,
	output logic      first,
	output logic      seen_out
);

	box_t box_q;
	logic hit_q;
	logic hit_d;
	logic ovl, cnt, eq;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			box_q <= wr_box;
		end
	end

	assign ovl = (box_q.hx >= qry.lx) && (box_q.lx <= qry.hx) &&
	             (box_q.hy >= qry.ly) && (box_q.ly <= qry.hy) &&
	             (box_q.hz >= qry.lz) && (box_q.lz <= qry.hz);
	assign cnt = (box_q.hx <= qry.hx) && (box_q.lx >= qry.lx) &&
	             (box_q.hy <= qry.hy) && (box_q.ly >= qry.ly) &&
	             (box_q.hz <= qry.hz) && (box_q.lz >= qry.lz);
	assign eq  = (box_q == qry);

	always_comb begin
		case (mode)
			CMD_OVERLAP:   hit_d = ovl;
			CMD_CONTAINED: hit_d = cnt;
			default:       hit_d = eq;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cap_en) begin
			hit_q <= hit_d;
		end
	end

	assign box      = box_q;
	assign hit      = hit_q & ctl.live;
	assign first    = hit & ~seen_in;
	assign seen_out = seen_in | hit;

endmodule

// ===== design/aabb_table_overlap_query.sv =====
// Top level of the box table overlap query block: command decode, entry
// count, result register and the row of aabb_cell entries. Depends on aabb_pkg.
//
// In the accept cycle every cell compares its stored box against the
// incoming box in parallel and registers the result; then, in the execute
// state, the hits are masked to the live entries, the lowest match is found
// along the cell chain, the table is edited and the response word is loaded.
// A new command word is taken once the previous one has committed, even while
// its response is still waiting to be taken; the commit itself waits while the
// response register is occupied and not being taken.
module aabb_table_overlap_query import aabb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                state_q;
	logic [2:0]            cmd_q;
	box_t                  qry_q;
	logic [SLOT_BITS-1:0]  slot_q;
	box_t                  last_box_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	box_t                  qry_in;
	logic                  accept;
	logic                  commit;
	cell_ctl_t             ctl [CAPACITY];
	box_t                  cell_box [CAPACITY];
	logic [CAPACITY-1:0]   hit_vec;
	logic [CAPACITY-1:0]   first_vec;
	logic [CAPACITY:0]     seen;
	logic [CAPACITY-1:0]   live;
	logic [CAPACITY-1:0]   slot_sel;
	logic [CAPACITY-1:0]   ins_sel;
	logic [CAPACITY-1:0]   wr_en;
	logic [CAPACITY-1:0]   mask_bits;
	logic [MASK_BITS-1:0]  mask_out;
	logic [IDX_BITS-1:0]   last_idx;
	logic [CMP_BITS-1:0]   slot_w;
	logic                  slot_ok;
	logic                  found;
	logic                  wr_last;
	logic                  use_hits;
	logic [CNT_BITS-1:0]   cnt_d;
	logic [1:0]            status_d;
	logic [CNT_BITS-1:0]   pop;
	box_t                  wr_box;

	assign qry_in = '{
		lx: COORD_BITS'(req.low_x),  ly: COORD_BITS'(req.low_y),
		lz: COORD_BITS'(req.low_z),  hx: COORD_BITS'(req.high_x),
		hy: COORD_BITS'(req.high_y), hz: COORD_BITS'(req.high_z)
	};

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid & req_ready;
	assign commit    = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign last_idx  = IDX_BITS'(count_q - CNT_BITS'(1));
	assign slot_w    = CMP_BITS'(slot_q);
	assign slot_ok   = slot_w < CMP_BITS'(count_q);
	assign found     = seen[CAPACITY];
	assign wr_box    = wr_last ? last_box_q : qry_q;
	assign seen[0]   = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign live[i]     = CNT_BITS'(i) < count_q;
		assign slot_sel[i] = (slot_w == CMP_BITS'(i));
		assign ins_sel[i]  = (count_q == CNT_BITS'(i));
		assign ctl[i]      = '{cap_en: accept, wr_en: commit & wr_en[i], live: live[i]};

		aabb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.mode     (req.cmd),
			.qry      (qry_in),
			.wr_box   (wr_box),
			.seen_in  (seen[i]),
			.box      (cell_box[i]),
			.hit      (hit_vec[i]),
			.first    (first_vec[i]),
			.seen_out (seen[i+1])
		);
	end

	always_comb begin
		wr_en    = '0;
		wr_last  = 1'b0;
		use_hits = 1'b0;
		cnt_d    = count_q;
		status_d = STAT_OK;
		case (cmd_q)
			CMD_INSERT: begin
				if (count_q == CNT_BITS'(CAPACITY)) begin
					status_d = STAT_FULL;
				end else begin
					wr_en = ins_sel;
					cnt_d = count_q + CNT_BITS'(1);
				end
			end
			CMD_UPDATE: begin
				if (!slot_ok) begin
					status_d = STAT_BAD_IDX;
				end else begin
					wr_en = slot_sel;
				end
			end
			CMD_ERASE_MATCH: begin
				if (!found) begin
					status_d = STAT_NO_MATCH;
				end else begin
					wr_en   = first_vec;
					wr_last = 1'b1;
					cnt_d   = count_q - CNT_BITS'(1);
				end
			end
			CMD_ERASE_INDEX: begin
				if (!slot_ok) begin
					status_d = STAT_BAD_IDX;
				end else begin
					wr_en   = slot_sel;
					wr_last = 1'b1;
					cnt_d   = count_q - CNT_BITS'(1);
				end
			end
			CMD_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				use_hits = 1'b1;
			end
		endcase
	end

	assign mask_bits = use_hits ? hit_vec : '0;
	assign pop       = CNT_BITS'($countones(mask_bits));

	for (genvar b = 0; b < MASK_BITS; b++) begin : g_mask
		if (b < CAPACITY) begin : g_on
			assign mask_out[b] = mask_bits[b];
		end else begin : g_off
			assign mask_out[b] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= req.cmd;
			qry_q      <= qry_in;
			slot_q     <= req.slot;
			last_box_q <= cell_box[last_idx];
		end
		if (commit) begin
			rsp_q.hit_mask     <= mask_out;
			rsp_q.any_hit      <= |mask_bits;
			rsp_q.hit_count    <= 6'(pop);
			rsp_q.entries_used <= 6'(cnt_d);
			rsp_q.status       <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				count_q <= cnt_d;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("more than one first match");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("entry count above capacity");

	a_query_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit && use_hits |=> count_q == $past(count_q))
		else $error("query changed entry count");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC && !req_ready)
		else $error("command not held for execution");

	a_edit_no_hits: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !use_hits |=> rsp_valid && rsp.hit_mask == '0 && !rsp.any_hit)
		else $error("edit command reported hits");

endmodule

// ===== test/aabb_table_overlap_query_checker.sv =====
// Checker for the box table overlap query block: predicts each response word
// from a local copy of the box table and compares it field by field.
// Depends on aabb_pkg.
module aabb_table_overlap_query_checker import aabb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   pending,
	output int   checked
);

	timeunit 1ns;
	timeprecision 1ps;

	box_t        stored_boxes[CAPACITY];
	int unsigned stored_count = 0;
	rsp_t        awaited_rsp[$];
	int          fail_count = 0;
	int          match_count = 0;

	function automatic bit box_hits(logic [2:0] c, box_t e, box_t q);
		case (c)
			CMD_OVERLAP: begin
				return e.hx >= q.lx && e.lx <= q.hx && e.hy >= q.ly && e.ly <= q.hy &&
					e.hz >= q.lz && e.lz <= q.hz;
			end
			CMD_CONTAINED: begin
				return e.hx <= q.hx && e.lx >= q.lx && e.hy <= q.hy && e.ly >= q.ly &&
					e.hz <= q.hz && e.lz >= q.lz;
			end
			default: begin
				return e == q;
			end
		endcase
	endfunction

	// last entry moves into the gap
	function automatic void drop_entry(int unsigned idx);
		if (idx != stored_count - 1)
			stored_boxes[idx] = stored_boxes[stored_count - 1];
		stored_count = stored_count - 1;
	endfunction

	function automatic rsp_t apply_table_command(req_t w);
		rsp_t        r;
		box_t        q;
		int unsigned s;
		int unsigned n;
		int          found;
		r = '0;
		n = 0;
		found = -1;
		s = 32'(w.slot);
		q.lx = w.low_x[COORD_BITS-1:0];
		q.ly = w.low_y[COORD_BITS-1:0];
		q.lz = w.low_z[COORD_BITS-1:0];
		q.hx = w.high_x[COORD_BITS-1:0];
		q.hy = w.high_y[COORD_BITS-1:0];
		q.hz = w.high_z[COORD_BITS-1:0];
		case (w.cmd)
			CMD_INSERT: begin
				if (stored_count >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					stored_boxes[stored_count] = q;
					stored_count = stored_count + 1;
				end
			end
			CMD_UPDATE: begin
				if (s >= stored_count || s >= CAPACITY)
					r.status = STAT_BAD_IDX;
				else
					stored_boxes[s] = q;
			end
			CMD_ERASE_MATCH: begin
				for (int i = 0; i < stored_count && found < 0; i++)
					if (stored_boxes[i] == q)
						found = i;
				if (found < 0)
					r.status = STAT_NO_MATCH;
				else
					drop_entry(found);
			end
			CMD_ERASE_INDEX: begin
				if (s >= stored_count || s >= CAPACITY)
					r.status = STAT_BAD_IDX;
				else
					drop_entry(s);
			end
			CMD_CLEAR: begin
				stored_count = 0;
			end
			default: begin
				for (int i = 0; i < stored_count; i++) begin
					if (box_hits(w.cmd, stored_boxes[i], q)) begin
						n = n + 1;
						if (i < MASK_BITS)
							r.hit_mask[i] = 1'b1;
					end
				end
			end
		endcase
		r.any_hit      = (n != 0);
		r.hit_count    = n[5:0];
		r.entries_used = stored_count[5:0];
		return r;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		if (!arst_n) begin
			stored_count = 0;
			awaited_rsp.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response word with nothing outstanding: %h", rsp);
					fail_count++;
				end else begin
					want = awaited_rsp.pop_front();
					match_count++;
					if (rsp.hit_mask !== want.hit_mask) begin
						$error("hit_mask: expected %h, got %h", want.hit_mask, rsp.hit_mask);
						fail_count++;
					end
					if (rsp.any_hit !== want.any_hit) begin
						$error("any_hit: expected %0d, got %0d", want.any_hit, rsp.any_hit);
						fail_count++;
					end
					if (rsp.hit_count !== want.hit_count) begin
						$error("hit_count: expected %0d, got %0d", want.hit_count,
							rsp.hit_count);
						fail_count++;
					end
					if (rsp.entries_used !== want.entries_used) begin
						$error("entries_used: expected %0d, got %0d", want.entries_used,
							rsp.entries_used);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.insert(awaited_rsp.size(), apply_table_command(req));
		end
		errors  <= fail_count;
		pending <= awaited_rsp.size();
		checked <= match_count;
	end

endmodule

// ===== test/aabb_table_overlap_query_tb.sv =====
// Testbench top for the box table overlap query block: clock, reset, directed
// and random command words under three flow-control mixes, and the verdict.
// Depends on aabb_pkg, aabb_table_overlap_query and aabb_table_overlap_query_checker.
module aabb_table_overlap_query_tb import aabb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   RANDOM_PER_PHASE = 342;
	localparam box_t ZERO_BOX = '0;
	localparam box_t FULL_BOX = '1;
	localparam box_t SPAN_BOX = {{3*COORD_BITS{1'b0}}, {3*COORD_BITS{1'b1}}};
	localparam box_t FLIP_BOX = ~SPAN_BOX;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int   errors;
	int   pending;
	int   checked;
	int   words_sent = 0;
	int   send_idle = 18;
	int   recv_stall = 51;
	box_t box_pool[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aabb_table_overlap_query u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	aabb_table_overlap_query_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic req_t word_of(logic [2:0] c, box_t b, int unsigned s);
		req_t w;
		w = '0;
		w.cmd    = c;
		w.low_x  = b.lx;
		w.low_y  = b.ly;
		w.low_z  = b.lz;
		w.high_x = b.hx;
		w.high_y = b.hy;
		w.high_z = b.hz;
		w.slot   = SLOT_BITS'(s);
		return w;
	endfunction

	// mostly small boxes near the origin so queries both hit and miss
	function automatic box_t random_box();
		box_t        b;
		int unsigned m;
		b = '0;
		m = $urandom_range(0, 9);
		if (m < 4 && box_pool.size() > 0) begin
			b = box_pool[$urandom_range(0, box_pool.size() - 1)];
		end else if (m == 7) begin
			b = {$urandom, $urandom, $urandom};
		end else if (m == 8) begin
			for (int k = 0; k < 6; k++)
				b[k*COORD_BITS +: COORD_BITS] = $urandom_range(0, 1) ? '1 : '0;
		end else begin
			b.lx = coord_t'($urandom_range(0, 12));
			b.ly = coord_t'($urandom_range(0, 12));
			b.lz = coord_t'($urandom_range(0, 12));
			b.hx = coord_t'(b.lx + $urandom_range(0, 6));
			b.hy = coord_t'(b.ly + $urandom_range(0, 6));
			b.hz = coord_t'(b.lz + $urandom_range(0, 6));
			if (m == 9)
				b.lx = coord_t'(b.hx + 1'b1);
		end
		return b;
	endfunction

	function automatic req_t random_word();
		box_t        b;
		logic [2:0]  c;
		int unsigned p;
		b = random_box();
		p = $urandom_range(0, 99);
		if (p < 30)
			c = CMD_INSERT;
		else if (p < 40)
			c = CMD_UPDATE;
		else if (p < 50)
			c = CMD_ERASE_MATCH;
		else if (p < 58)
			c = CMD_ERASE_INDEX;
		else if (p < 60)
			c = CMD_CLEAR;
		else if (p < 75)
			c = CMD_OVERLAP;
		else if (p < 87)
			c = CMD_CONTAINED;
		else
			c = CMD_MEMBER;
		if (c == CMD_INSERT || c == CMD_UPDATE) begin
			box_pool.insert(box_pool.size(), b);
			if (box_pool.size() > 48)
				void'(box_pool.pop_front());
		end
		return word_of(c, b, $urandom_range(0, 31));
	endfunction

	task automatic send(req_t w);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
	endtask

	initial begin : stimulus
		box_t mid_box;
		box_t odd_box;
		mid_box = {16'd100, 16'd100, 16'd100, 16'd200, 16'd200, 16'd200};
		odd_box = {16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(word_of(CMD_OVERLAP, SPAN_BOX, 0));
		send(word_of(CMD_ERASE_MATCH, ZERO_BOX, 0));
		send(word_of(CMD_ERASE_INDEX, ZERO_BOX, 0));
		send(word_of(CMD_UPDATE, FULL_BOX, 31));
		send(word_of(CMD_INSERT, ZERO_BOX, 0));
		send(word_of(CMD_INSERT, FULL_BOX, 31));
		send(word_of(CMD_INSERT, SPAN_BOX, 0));
		send(word_of(CMD_INSERT, FLIP_BOX, 0));
		send(word_of(CMD_INSERT, FULL_BOX, 0));
		send(word_of(CMD_INSERT, mid_box, 0));
		send(word_of(CMD_OVERLAP, SPAN_BOX, 0));
		send(word_of(CMD_OVERLAP, mid_box, 0));
		send(word_of(CMD_CONTAINED, SPAN_BOX, 0));
		send(word_of(CMD_CONTAINED, mid_box, 0));
		send(word_of(CMD_MEMBER, FULL_BOX, 0));
		send(word_of(CMD_MEMBER, mid_box, 0));
		send(word_of(CMD_ERASE_MATCH, FULL_BOX, 0));
		send(word_of(CMD_ERASE_MATCH, odd_box, 0));
		send(word_of(CMD_UPDATE, mid_box, 1));
		send(word_of(CMD_UPDATE, odd_box, 5));
		send(word_of(CMD_ERASE_INDEX, ZERO_BOX, 4));
		send(word_of(CMD_ERASE_INDEX, ZERO_BOX, 0));
		send(word_of(CMD_ERASE_INDEX, ZERO_BOX, 31));
		send(word_of(CMD_MEMBER, mid_box, 0));
		send(word_of(CMD_CLEAR, FULL_BOX, 31));
		send(word_of(CMD_OVERLAP, SPAN_BOX, 0));

		for (int ph = 0; ph < 3; ph++) begin
			send_idle  = (ph == 0) ? 18 : (ph == 1) ? 51 : 0;
			recv_stall = (ph == 0) ? 51 : (ph == 1) ? 18 : 0;
			repeat (RANDOM_PER_PHASE)
				send(random_word());
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Summary: %0d command words (directed edits and queries, then random",
			words_sent);
		$display("traffic under three idle/stall mixes), %0d response words compared",
			checked);
		if (errors == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (pending != 0)
				$error("%0d expected responses never arrived", pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
